// File: sv/msi_pkg.sv
// ----------------------------------------------------------------------------
// msi_pkg
// shared types and constants for the snooping coherence block
// ----------------------------------------------------------------------------
package msi_pkg;
    localparam int PROCS     = 4;
    localparam int PROC_W    = 2;
    localparam int LINES     = 512;
    localparam int IDX_W     = 9;
    localparam int TAG_W     = 21;
    localparam int CNT_W     = 32;

    typedef enum logic [1:0] {ST_I = 2'd0, ST_S = 2'd1, ST_E = 2'd2, ST_M = 2'd3} line_st_t;

    typedef enum logic [1:0] {CLS_NONE = 2'd0, CLS_PRIV = 2'd1, CLS_PUB = 2'd2} cls_t;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE, S_OUT} ctl_state_t;

    typedef struct packed {
        logic capture;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic clearing;
    } sts_t;
endpackage

// File: sv/msi_datapath.sv
// ----------------------------------------------------------------------------
// msi_datapath
// per-processor tag and state stores, snoop logic, counters, result register
// ----------------------------------------------------------------------------
module msi_datapath
    import msi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                protocol_select,
    input  logic [PROC_W-1:0]   requester,
    input  logic                mode,
    input  logic [31:0]         address,
    input  logic                out_take,
    output sts_t                sts,
    output logic                hit,
    output logic [1:0]          access_class,
    output logic [1:0]          final_state,
    output logic [1:0]          lines_invalidated,
    output logic                broadcast_sent,
    output logic [CNT_W-1:0]    hit_total,
    output logic [CNT_W-1:0]    miss_total,
    output logic [CNT_W-1:0]    broadcast_total,
    output logic [CNT_W-1:0]    invalidation_total,
    output logic [CNT_W-1:0]    private_total,
    output logic [CNT_W-1:0]    public_total
);
    logic [TAG_W-1:0]  tag_mem [PROCS][LINES];
    logic [1:0]        st_mem  [PROCS][LINES];
    logic [TAG_W-1:0]  tag_rd  [PROCS];
    logic [1:0]        st_rd   [PROCS];

    logic [PROC_W-1:0] req_reg;
    logic              wr_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              busy_reg;
    logic              clr_busy_reg;
    logic [IDX_W-1:0]  clr_idx_reg;

    logic [CNT_W-1:0]  hit_reg, miss_reg, bc_reg, inv_reg, priv_reg, pub_reg;

    logic [1:0]        cur_st [PROCS];
    logic [1:0]        new_st [PROCS];
    logic              wr_en  [PROCS];
    logic              shared;
    logic [PROC_W:0]   ninv;
    logic              match;
    logic [1:0]        rst_st;
    logic              hit_c;
    logic [1:0]        cls_c;
    logic [1:0]        fin_c;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [PROC_W:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-PROC_W){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // synchronous read of every store at the access index
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int p = 0; p < PROCS; p++)
            begin
                tag_rd[p] <= tag_mem[p][address[IDX_W+1:2]];
                st_rd[p]  <= st_mem[p][address[IDX_W+1:2]];
            end
        end
        // clearing pass after reset marks every line invalid
        if (clr_busy_reg)
        begin
            for (int p = 0; p < PROCS; p++)
                st_mem[p][clr_idx_reg] <= ST_I;
        end
        else
        begin
            for (int p = 0; p < PROCS; p++)
            begin
                if (wr_en[p])
                begin
                    st_mem[p][idx_reg] <= new_st[p];
                    if (p == int'(req_reg))
                        tag_mem[p][idx_reg] <= tag_reg;
                end
            end
        end
    end

    always_comb
    begin
        shared = 1'b0;
        ninv   = '0;
        for (int p = 0; p < PROCS; p++)
        begin
            cur_st[p] = st_rd[p];
            if (p != int'(req_reg) && cur_st[p] != ST_I)
            begin
                shared = 1'b1;
                ninv   = ninv + 1'b1;
            end
        end
        rst_st = cur_st[req_reg];
        match  = (tag_rd[req_reg] == tag_reg) && (rst_st != ST_I);
        hit_c  = wr_reg ? (match && (rst_st == ST_M || rst_st == ST_E)) : match;
        cls_c  = CLS_NONE;
        if (!wr_reg && match)
            cls_c = (rst_st == ST_S) ? CLS_PUB : CLS_PRIV;
        for (int p = 0; p < PROCS; p++)
        begin
            new_st[p] = cur_st[p];
            wr_en[p]  = 1'b0;
            if (p == int'(req_reg))
            begin
                if (wr_reg)
                    new_st[p] = ST_M;
                else if (!match)
                    new_st[p] = (protocol_select && !shared) ? ST_E : ST_S;
                wr_en[p] = cmd.update;
            end
            else if (!hit_c)
            begin
                if (wr_reg)
                    new_st[p] = ST_I;
                else if (cur_st[p] == ST_M || cur_st[p] == ST_E)
                    new_st[p] = ST_S;
                wr_en[p] = cmd.update;
            end
        end
        fin_c = new_st[req_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg <= '0;
            busy_reg <= 1'b0;
            hit_reg <= '0; miss_reg <= '0; bc_reg <= '0;
            inv_reg <= '0; priv_reg <= '0; pub_reg <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (&clr_idx_reg)
                    clr_busy_reg <= 1'b0;
            end
            if (cmd.update)
            begin
                busy_reg <= 1'b1;
                if (hit_c)
                    hit_reg <= sat_add(hit_reg, {{PROC_W{1'b0}}, 1'b1});
                else
                    miss_reg <= sat_add(miss_reg, {{PROC_W{1'b0}}, 1'b1});
                if (cls_c == CLS_PRIV)
                    priv_reg <= sat_add(priv_reg, {{PROC_W{1'b0}}, 1'b1});
                if (cls_c == CLS_PUB)
                    pub_reg <= sat_add(pub_reg, {{PROC_W{1'b0}}, 1'b1});
                if (wr_reg && !hit_c)
                begin
                    inv_reg <= sat_add(inv_reg, ninv);
                    if (ninv != '0)
                        bc_reg <= sat_add(bc_reg, {{PROC_W{1'b0}}, 1'b1});
                end
            end
            else if (out_take)
                busy_reg <= 1'b0;
        end
    end

    // captured access fields and result word fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= requester;
            wr_reg  <= mode;
            idx_reg <= address[IDX_W+1:2];
            tag_reg <= address[31:11];
        end
        if (cmd.update)
        begin
            hit               <= hit_c;
            access_class      <= cls_c;
            final_state       <= fin_c;
            lines_invalidated <= (wr_reg && !hit_c) ?
                                 ((ninv > 3'd3) ? 2'd3 : ninv[1:0]) : 2'd0;
            broadcast_sent    <= wr_reg && !hit_c && (ninv != '0);
        end
    end

    assign sts.out_busy       = busy_reg;
    assign sts.clearing       = clr_busy_reg;
    assign hit_total          = hit_reg;
    assign miss_total         = miss_reg;
    assign broadcast_total    = bc_reg;
    assign invalidation_total = inv_reg;
    assign private_total      = priv_reg;
    assign public_total       = pub_reg;
endmodule

// File: sv/msi_ctrl.sv
// ----------------------------------------------------------------------------
// msi_ctrl
// access sequencer: capture, read stores, write back, hold result
// ----------------------------------------------------------------------------
module msi_ctrl
    import msi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_ready,
    input  sts_t sts,
    output logic in_ready,
    output logic out_valid,
    output cmd_t cmd
);
    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !sts.clearing && (!sts.out_busy || out_ready);
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                if (!sts.out_busy)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WRITE: state_next = S_IDLE;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        out_valid = sts.out_busy;
    end
endmodule

// File: sv/msi_mesi_snoop_coherence.sv
// ----------------------------------------------------------------------------
// msi_mesi_snoop_coherence
// snooping MSI/MESI tag and state controller for four private caches
// ----------------------------------------------------------------------------
// An access first reads the tag and state stores of all caches at the line
// index, then decides and writes the line back once no result is held. The next
// word is accepted only when no result is held or in the cycle the held result
// is taken. After reset a clearing pass over all 512 line indices marks every
// line invalid, with in_ready low throughout. Counters saturate at all ones.
module msi_mesi_snoop_coherence
    import msi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        requester,
    input  logic              mode,
    input  logic [31:0]       address,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [1:0]        access_class,
    output logic [1:0]        final_state,
    output logic [1:0]        lines_invalidated,
    output logic              broadcast_sent,
    output logic [31:0]       hit_total,
    output logic [31:0]       miss_total,
    output logic [31:0]       broadcast_total,
    output logic [31:0]       invalidation_total,
    output logic [31:0]       private_total,
    output logic [31:0]       public_total
);
    cmd_t cmd;
    sts_t sts;
    logic proto_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            proto_reg <= 1'b0;
        else if (cfg_we)
            proto_reg <= cfg_wdata;
    end

    msi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .out_ready(out_ready),
        .sts(sts), .in_ready(in_ready), .out_valid(out_valid), .cmd(cmd)
    );

    msi_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .protocol_select(proto_reg),
        .requester(requester), .mode(mode), .address(address),
        .out_take(out_valid && out_ready), .sts(sts),
        .hit(hit), .access_class(access_class), .final_state(final_state),
        .lines_invalidated(lines_invalidated), .broadcast_sent(broadcast_sent),
        .hit_total(hit_total), .miss_total(miss_total),
        .broadcast_total(broadcast_total), .invalidation_total(invalidation_total),
        .private_total(private_total), .public_total(public_total)
    );

    a_upd_after_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $past(cmd.capture) || $past(cmd.update) == 1'b0)
        else $error("update without capture");
    a_write_final_m: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && hit == 1'b0 && access_class != 2'd0 |-> 1'b0)
        else $error("miss with hit class");
    a_priv_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && access_class == 2'd1 |-> final_state == 2'd2 || final_state == 2'd3)
        else $error("private hit on shared line");
endmodule

// File: tb/msi_coherence_checker.sv
// ----------------------------------------------------------------------------
// msi_coherence_checker
// watches the access and result channels of the snooping coherence block,
// keeps its own copy of every cache line and counter, and compares each
// result word field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module msi_coherence_checker
    import msi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  requester,
    input  logic        mode,
    input  logic [31:0] address,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        hit,
    input  logic [1:0]  access_class,
    input  logic [1:0]  final_state,
    input  logic [1:0]  lines_invalidated,
    input  logic        broadcast_sent,
    input  logic [31:0] hit_total,
    input  logic [31:0] miss_total,
    input  logic [31:0] broadcast_total,
    input  logic [31:0] invalidation_total,
    input  logic [31:0] private_total,
    input  logic [31:0] public_total,
    output int          fail_count,
    output int          pending,
    output int          hit_words,
    output int          broadcast_words
);
    typedef struct packed {
        logic        hit;
        cls_t        cls;
        line_st_t    fin;
        logic [1:0]  ninv;
        logic        bc;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] broadcasts;
        logic [31:0] invalidations;
        logic [31:0] privates;
        logic [31:0] publics;
    } access_result_t;

    line_st_t       line_state [PROCS][LINES];
    logic [TAG_W-1:0] line_tag [PROCS][LINES];
    logic [31:0]    hits, misses, broadcasts, invalidations, privates, publics;
    logic           mesi_mode;
    access_result_t expected_results [$];

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    function automatic access_result_t predict_access(logic [1:0] req, logic wr,
                                                      logic [31:0] addr);
        access_result_t r;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tg;
        line_st_t st;
        logic match, shared;
        int n;
        r = '0;
        idx = addr[10:2];
        tg = addr[31:11];
        st = line_state[req][idx];
        match = (line_tag[req][idx] == tg) && st != ST_I;
        shared = 1'b0;
        n = 0;
        if (!wr) begin
            if (match) begin
                r.hit = 1'b1;
                hits = sat_add(hits, 1);
                if (st == ST_S) begin
                    r.cls = CLS_PUB;
                    publics = sat_add(publics, 1);
                end
                else begin
                    r.cls = CLS_PRIV;
                    privates = sat_add(privates, 1);
                end
            end
            else begin
                misses = sat_add(misses, 1);
                for (int p = 0; p < PROCS; p++) begin
                    if (p != req) begin
                        if (line_state[p][idx] != ST_I)
                            shared = 1'b1;
                        if (line_state[p][idx] inside {ST_M, ST_E})
                            line_state[p][idx] = ST_S;
                    end
                end
                line_state[req][idx] = (mesi_mode && !shared) ? ST_E : ST_S;
                line_tag[req][idx] = tg;
            end
        end
        else begin
            if (match && st inside {ST_M, ST_E}) begin
                r.hit = 1'b1;
                hits = sat_add(hits, 1);
            end
            else begin
                misses = sat_add(misses, 1);
                for (int p = 0; p < PROCS; p++) begin
                    if (p != req && line_state[p][idx] != ST_I) begin
                        line_state[p][idx] = ST_I;
                        n++;
                    end
                end
                invalidations = sat_add(invalidations, n);
                if (n != 0) begin
                    r.bc = 1'b1;
                    broadcasts = sat_add(broadcasts, 1);
                end
                r.ninv = (n > 3) ? 2'd3 : n[1:0];
                line_tag[req][idx] = tg;
            end
            line_state[req][idx] = ST_M;
        end
        r.fin = line_state[req][idx];
        r.hits = hits;
        r.misses = misses;
        r.broadcasts = broadcasts;
        r.invalidations = invalidations;
        r.privates = privates;
        r.publics = publics;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        access_result_t e;
        if (!rst_n) begin
            for (int p = 0; p < PROCS; p++)
                for (int i = 0; i < LINES; i++) begin
                    line_state[p][i] = ST_I;
                    line_tag[p][i] = '0;
                end
            {hits, misses, broadcasts, invalidations, privates, publics} = '0;
            mesi_mode = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            hit_words = 0;
            broadcast_words = 0;
        end
        else begin
            // result first: a word accepted on this edge cannot belong to this edge's input
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else begin
                    e = expected_results.pop_front();
                    check_field("hit", e.hit, hit);
                    check_field("access_class", e.cls, access_class);
                    check_field("final_state", e.fin, final_state);
                    check_field("lines_invalidated", e.ninv, lines_invalidated);
                    check_field("broadcast_sent", e.bc, broadcast_sent);
                    check_field("hit_total", e.hits, hit_total);
                    check_field("miss_total", e.misses, miss_total);
                    check_field("broadcast_total", e.broadcasts, broadcast_total);
                    check_field("invalidation_total", e.invalidations, invalidation_total);
                    check_field("private_total", e.privates, private_total);
                    check_field("public_total", e.publics, public_total);
                    hit_words += e.hit;
                    broadcast_words += e.bc;
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_access(requester, mode, address));
            if (cfg_we)
                mesi_mode = cfg_wdata;
            pending = expected_results.size();
        end
    end
endmodule

// File: tb/tb_msi_mesi_snoop_coherence.sv
// ----------------------------------------------------------------------------
// tb_msi_mesi_snoop_coherence
// drives directed and random cache accesses into the coherence block under
// MSI and MESI, with varied sender gaps and receiver stalls; the checker
// beside the block predicts every result word and counts mismatches
// ----------------------------------------------------------------------------
module tb_msi_mesi_snoop_coherence;
    import msi_pkg::*;

    localparam int LIMIT = 2_000_000;
    localparam logic RD = 1'b0;
    localparam logic WR = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  requester = '0;
    logic        mode = 1'b0;
    logic [31:0] address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        hit, broadcast_sent;
    logic [1:0]  access_class, final_state, lines_invalidated;
    logic [31:0] hit_total, miss_total, broadcast_total;
    logic [31:0] invalidation_total, private_total, public_total;
    int          fail_count, pending, hit_words, broadcast_words;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;
    int          words_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    msi_mesi_snoop_coherence u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .requester(requester),
        .mode(mode), .address(address), .out_valid(out_valid),
        .out_ready(out_ready), .hit(hit), .access_class(access_class),
        .final_state(final_state), .lines_invalidated(lines_invalidated),
        .broadcast_sent(broadcast_sent), .hit_total(hit_total),
        .miss_total(miss_total), .broadcast_total(broadcast_total),
        .invalidation_total(invalidation_total), .private_total(private_total),
        .public_total(public_total)
    );

    msi_coherence_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_ready <= ($urandom_range(99) >= stall_pct);
        if (cycles > LIMIT) begin
            $display("FAIL msi_mesi_snoop_coherence");
            $finish;
        end
    end

    task automatic send_access(logic [1:0] req, logic wr, logic [31:0] addr);
        in_valid <= 1'b1;
        requester <= req;
        mode <= wr;
        address <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 60)
                @(posedge clk);
        end
    endtask

    // hold off the sender until all results are back, then let the pipe settle
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_protocol(logic mesi);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= mesi;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly a handful of indices and tags so that lines get shared and reused
    function automatic logic [31:0] pick_address();
        logic [20:0] tg;
        logic [8:0]  idx;
        if ($urandom_range(99) < 12)
            return $urandom;
        case ($urandom_range(3))
            0: tg = '0;
            1: tg = 21'd1;
            2: tg = 21'h1fffff;
            default: tg = 21'($urandom);
        endcase
        idx = ($urandom_range(9) == 0) ? 9'h1ff : 9'($urandom_range(5));
        return {tg, idx, 2'($urandom)};
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_protocol(1'b1);
        // exclusive read, private hit, silent upgrade, then downgrade by a reader
        send_access(2'd0, RD, 32'h0000_0000);
        send_access(2'd0, RD, 32'h0000_0003);
        send_access(2'd0, WR, 32'h0000_0000);
        send_access(2'd1, RD, 32'h0000_0000);
        send_access(2'd1, RD, 32'h0000_0000);
        send_access(2'd2, RD, 32'h0000_0000);
        send_access(2'd3, RD, 32'h0000_0000);
        // write miss with three sharers: full invalidation
        send_access(2'd3, WR, 32'h0000_0000);
        // stale tag at the same index still snooped
        send_access(2'd2, RD, 32'hffff_f800);
        send_access(2'd1, WR, 32'hffff_ffff);
        send_access(2'd0, RD, 32'hffff_ffff);
        send_access(2'd2, WR, 32'h0000_07fc);
        // exclusive line left over into msi operation
        send_access(2'd3, RD, 32'h0000_1234);
        set_protocol(1'b0);
        send_access(2'd3, RD, 32'h0000_1234);
        send_access(2'd3, WR, 32'h0000_1234);
        send_access(2'd0, RD, 32'h0000_5678);
        send_access(2'd1, RD, 32'h0000_5678);
        send_access(2'd0, RD, 32'h0000_5678);
        send_access(2'd0, WR, 32'h0000_5678);
        send_access(2'd2, WR, 32'h0000_5678);
        send_access(2'd2, WR, 32'haaaa_5555);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_protocol(ph[0]);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 53; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            for (int k = 0; k < 216; k++)
                send_access(2'($urandom_range(3)), 1'($urandom_range(1)),
                            pick_address());
        end
        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d accesses under msi and mesi, %0d hits, %0d broadcasts",
                 words_sent, hit_words, broadcast_words);
        if (fail_count == 0)
            $display("PASS msi_mesi_snoop_coherence");
        else
            $display("FAIL msi_mesi_snoop_coherence");
        $finish;
    end
endmodule
